/* design/glob_wildcard_matcher_defines.svh */
// Assertion macros shared by the glob wildcard matcher checker.
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GWM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GWM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gwm_pkg.sv */
// Constants, register codes and helper functions for the glob wildcard matcher.
`default_nettype none

package gwm_pkg;

  // Fixed field widths
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned NUM_WORDS    = 4;
  localparam int unsigned STORED_CHARS = 32;

  // Pattern metacharacters
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  // Case folding bounds
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_e;

  // Fold ASCII lower case letters to upper case
  function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? (c - CASE_DELTA) : c;
  endfunction

endpackage

`default_nettype wire

/* design/glob_wildcard_matcher.sv */
// Streaming glob matcher: subject characters in, one match flag per subject out.
//
// Channels: the slave stream takes one subject character per item in tdata, the
// final character flagged by tlast, and tuser set for an empty subject (tdata
// ignored then). The master stream returns one item per subject, tdata bit 0
// set when the whole subject matches the whole configured pattern. The config
// channel writes pattern_length (index 0) and pattern words 0..3 (index 1..4);
// it is always ready and must be written only while the block is idle.
// Throughput: one character per cycle, sustained, including across subject
// boundaries, unless an end-of-subject item waits behind a stalled result; the
// whole position-set update (star closure, advance, closure) is one
// combinational pass between the input register and the state/result
// registers. An end item passes the input register, then the result register.
// Stall: a waiting result holds in the output register while characters keep
// flowing; only an end-of-subject item behind a stalled result waits, and
// then the slave side deasserts tready.
// Reset: pattern cleared to length zero, position set back to start, both
// registers emptied.
`default_nettype none

module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Subject stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] subject_char
  input  wire logic                   s_axis_tlast,   // last_char
  input  wire logic                   s_axis_tuser,   // [0] empty_subject
  // Result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [7:0]                  m_axis_tdata    // [0] matched, [7:1] zero
);

  localparam int unsigned W     = MAX_PATTERN + 1;
  localparam int unsigned STEPS = $clog2(W);
  localparam int unsigned IDX_W = $clog2(W);
  localparam logic [W-1:0] START_SET = W'(1);

  // Configuration registers
  logic [LEN_W-1:0]                          pattern_length_q;
  logic [NUM_WORDS-1:0][CFG_DATA_W-1:0]      pattern_word_q;

  // Input register
  logic              in_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              empty_q;

  // Position set and result register
  logic [W-1:0] act_q, act_d;
  logic         m_valid_q;
  logic         matched_q, matched_d;

  logic ends_item;
  logic fire;
  logic in_accept;

  logic [LEN_W-1:0]                eff_len;
  logic [STORED_CHARS*CHAR_W-1:0]  pat_flat;
  logic [MAX_PATTERN-1:0][CHAR_W-1:0] pat_char;

  logic [W-1:0] star_v, step_ok_v, below_len_v, upto_len_v, prop_v;
  logic [W-1:0] closed_in, live, adv_set, closed_adv, final_set;

  // Star closure as a log-depth prefix over runs of '*'
  function automatic logic [W-1:0] close_set(input logic [W-1:0] set_in,
                                             input logic [W-1:0] prop_in);
    logic [W-1:0] reach;
    logic [W-1:0] prop;
    reach = set_in;
    prop  = prop_in;
    for (int k = 0; k < STEPS; k++) begin
      reach = reach | ((reach & prop) << (1 << k));
      prop  = prop & (prop >> (1 << k));
    end
    return reach;
  endfunction

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= '0;
      pattern_word_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PATTERN_LENGTH: pattern_length_q  <= cfg_data_i[LEN_W-1:0];
        REG_PATTERN_WORD_0: pattern_word_q[0] <= cfg_data_i;
        REG_PATTERN_WORD_1: pattern_word_q[1] <= cfg_data_i;
        REG_PATTERN_WORD_2: pattern_word_q[2] <= cfg_data_i;
        REG_PATTERN_WORD_3: pattern_word_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate the pattern length
  assign eff_len = (pattern_length_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                            : pattern_length_q;

  // Unpack pattern characters; positions past storage read as zero
  assign pat_flat = pattern_word_q;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < STORED_CHARS) begin
        pat_char[i] = pat_flat[(i % STORED_CHARS) * CHAR_W +: CHAR_W];
      end else begin
        pat_char[i] = '0;
      end
    end
  end

  // Per-position pattern classes and compare against the current character
  always_comb begin
    star_v    = '0;
    step_ok_v = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      star_v[i] = (pat_char[i] == CH_STAR);
      if (pat_char[i] == CH_QUEST) begin
        step_ok_v[i] = (char_q != CH_DOT);
      end else begin
        step_ok_v[i] = !star_v[i] && (fold_upper(pat_char[i]) == fold_upper(char_q));
      end
    end
    for (int i = 0; i < W; i++) begin
      below_len_v[i] = (LEN_W'(i) < eff_len);
      upto_len_v[i]  = (LEN_W'(i) <= eff_len);
    end
  end

  assign prop_v = star_v & below_len_v;

  // Close, advance by one character, close again
  assign closed_in  = close_set(act_q & upto_len_v, prop_v);
  assign live       = closed_in & below_len_v;
  assign adv_set    = (live & star_v) | ((live & step_ok_v) << 1);
  assign closed_adv = close_set(adv_set & upto_len_v, prop_v);
  assign final_set  = empty_q ? closed_in : closed_adv;

  assign matched_d = final_set[eff_len[IDX_W-1:0]];
  assign act_d     = ends_item ? START_SET : closed_adv;

  // Handshake: an end item waits only behind a stalled result
  assign ends_item     = empty_q || last_q;
  assign fire          = in_valid_q && (!ends_item || !m_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q  <= s_axis_tdata;
      last_q  <= s_axis_tlast;
      empty_q <= s_axis_tuser;
    end
  end

  // Advance the position set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= START_SET;
    end else if (fire) begin
      act_q <= act_d;
    end
  end

  // Result register: load on subject end, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire && ends_item) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ends_item) begin
      matched_q <= matched_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, matched_q};

endmodule

`default_nettype wire

/* design/gwm_checker.sv */
// Port-level assertion checker for the glob wildcard matcher, with its bind.
`default_nettype none

`include "glob_wildcard_matcher_defines.svh"

module gwm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [63:0] cfg_data_i,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);

  // Hold a stalled result
  `GWM_ASSERT_NEXT(a_result_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `GWM_ASSERT_NEXT(a_result_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

  // Backpressure only behind a stalled result
  `GWM_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a stalled result")

  // A fresh result follows an accepted subject end
  `GWM_ASSERT_SAME(a_result_origin, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser), 2), "result without a subject end")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

`default_nettype wire
